/* design/e2i_pkg.sv */
package e2i_pkg;

  localparam int DAY_BITS  = 16;
  localparam int HOUR_BITS = 5;
  localparam int MIN_BITS  = 6;
  localparam int YEAR_BITS = 8;
  localparam int TEXT_LEN  = 20;
  localparam int IDX_W     = 5;

  localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
  localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
  localparam logic [31:0] SECS_PER_MIN  = 32'd60;
  localparam logic [11:0] BASE_YEAR     = 12'd1970;

  // reciprocals: seconds >> 7 by 675, >> 4 by 225, >> 2 by 15
  localparam logic [25:0] DAY_RECIP   = 26'd50903317;
  localparam int          DAY_SHIFT   = 35;
  localparam logic [13:0] HOUR_RECIP  = 14'd9321;
  localparam int          HOUR_SHIFT  = 21;
  localparam logic [10:0] MIN_RECIP   = 11'd1093;
  localparam int          MIN_SHIFT   = 14;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_Z     = 8'h5A;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_DAY,
    OP_DIV_HOUR,
    OP_DIV_MIN,
    OP_YEAR,
    OP_DOY,
    OP_MONTH,
    OP_DOM,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic hit;
  } stat_t;

  // days from 1970-01-01 to jan 1 of year 1970 + yi, valid through 2200
  function automatic logic [16:0] year_start(input logic [7:0] yi);
    logic [11:0] n;
    logic [16:0] lin;
    logic [16:0] lp;
    n   = 12'd1969 + {4'd0, yi};
    lin = {9'd0, yi} * 17'd365;
    lp  = {7'd0, n[11:2]} - 17'd492 - {16'd0, (n >= 12'd2100)};
    return lin + lp;
  endfunction

  function automatic logic is_leap(input logic [11:0] y);
    return (y[1:0] == 2'd0) && (y != 12'd2100);
  endfunction

  // days of the year before the first of month m
  function automatic logic [8:0] cum_days(input logic [3:0] m, input logic leap);
    logic [8:0] c;
    case (m)
      4'd1:    c = 9'd0;
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    if (leap && (m >= 4'd3)) begin
      c = c + 9'd1;
    end
    return c;
  endfunction

  function automatic logic [3:0] tens_of(input logic [6:0] v);
    logic [3:0] t;
    t = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (v >= 7'(10 * k)) begin
        t = 4'(k);
      end
    end
    return t;
  endfunction

endpackage

/* design/e2i_datapath.sv */
module e2i_datapath import e2i_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] in_data,
  input  cmd_t        cmd,
  output stat_t       stat,
  output logic [7:0]  out_char,
  output logic        out_last
);

  logic [31:0]          rem;
  logic [DAY_BITS-1:0]  day_q;
  logic [HOUR_BITS-1:0] hh_q;
  logic [MIN_BITS-1:0]  mm_q;
  logic [YEAR_BITS-1:0] yidx;
  logic [8:0]           doy;

  logic                 cache_valid;
  logic [15:0]          cached_day_number;
  logic [11:0]          cached_year;
  logic [3:0]           cached_month;
  logic [4:0]           cached_day_of_month;

  logic [50:0]          day_prod;
  logic [26:0]          hour_prod;
  logic [20:0]          min_prod;

  logic [YEAR_BITS-1:0] y_cand;
  logic                 y_ok;
  logic [16:0]          doy_full;
  logic                 leap;
  logic [3:0]           month_calc;
  logic [8:0]           dom_full;

  logic [6:0]           yr_hi;
  logic [11:0]          yr_base;
  logic [6:0]           yr_lo;
  logic [6:0]           pv;
  logic                 is_digit;
  logic                 use_tens;
  logic [7:0]           fixed_ch;
  logic [3:0]           tens;
  logic [6:0]           ones_full;
  logic [3:0]           digit;
  logic [7:0]           ch;

  // quotients by constant reciprocal multiplication
  assign day_prod  = {26'd0, rem[31:7]} * {25'd0, DAY_RECIP};
  assign hour_prod = {14'd0, rem[16:4]} * {13'd0, HOUR_RECIP};
  assign min_prod  = {11'd0, rem[11:2]} * {10'd0, MIN_RECIP};

  // year search, day of year, month, day of month
  always_comb begin
    y_cand   = yidx | (8'd1 << cmd.idx[2:0]);
    y_ok     = year_start(y_cand) <= {1'b0, day_q};
    doy_full = {1'b0, day_q} - year_start(yidx);
    leap     = is_leap(cached_year);
    month_calc = 4'd1;
    for (int m = 2; m <= 12; m++) begin
      if (doy >= cum_days(4'(m), leap)) begin
        month_calc = month_calc + 4'd1;
      end
    end
    dom_full = doy - cum_days(cached_month, leap) + 9'd1;
  end

  assign stat.hit = cache_valid && (cached_day_number == day_q);

  // character select
  always_comb begin
    if (cached_year >= 12'd2100) begin
      yr_hi   = 7'd21;
      yr_base = 12'd2100;
    end else if (cached_year >= 12'd2000) begin
      yr_hi   = 7'd20;
      yr_base = 12'd2000;
    end else begin
      yr_hi   = 7'd19;
      yr_base = 12'd1900;
    end
    yr_lo    = 7'(cached_year - yr_base);
    pv       = 7'd0;
    is_digit = 1'b1;
    use_tens = 1'b0;
    fixed_ch = CH_Z;
    unique case (cmd.idx)
      5'd0:  begin pv = yr_hi; use_tens = 1'b1; end
      5'd1:  pv = yr_hi;
      5'd2:  begin pv = yr_lo; use_tens = 1'b1; end
      5'd3:  pv = yr_lo;
      5'd4:  begin is_digit = 1'b0; fixed_ch = CH_DASH; end
      5'd5:  begin pv = {3'd0, cached_month}; use_tens = 1'b1; end
      5'd6:  pv = {3'd0, cached_month};
      5'd7:  begin is_digit = 1'b0; fixed_ch = CH_DASH; end
      5'd8:  begin pv = {2'd0, cached_day_of_month}; use_tens = 1'b1; end
      5'd9:  pv = {2'd0, cached_day_of_month};
      5'd10: begin is_digit = 1'b0; fixed_ch = CH_T; end
      5'd11: begin pv = {2'd0, hh_q}; use_tens = 1'b1; end
      5'd12: pv = {2'd0, hh_q};
      5'd13: begin is_digit = 1'b0; fixed_ch = CH_COLON; end
      5'd14: begin pv = {1'b0, mm_q}; use_tens = 1'b1; end
      5'd15: pv = {1'b0, mm_q};
      5'd16: begin is_digit = 1'b0; fixed_ch = CH_COLON; end
      5'd17: begin pv = {1'b0, rem[5:0]}; use_tens = 1'b1; end
      5'd18: pv = {1'b0, rem[5:0]};
      default: begin is_digit = 1'b0; fixed_ch = CH_Z; end
    endcase
    tens      = tens_of(pv);
    ones_full = pv - 7'({3'd0, tens} * 7'd10);
    digit     = use_tens ? tens : ones_full[3:0];
    ch        = is_digit ? (CH_ZERO + {4'd0, digit}) : fixed_ch;
  end

  // idx 1 takes the quotient, idx 0 the remainder
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        rem   <= in_data;
        day_q <= '0;
        hh_q  <= '0;
        mm_q  <= '0;
        yidx  <= '0;
      end
      OP_DIV_DAY: begin
        if (cmd.idx[0]) begin
          day_q <= day_prod[DAY_SHIFT +: DAY_BITS];
        end else begin
          rem <= rem - ({16'd0, day_q} * SECS_PER_DAY);
        end
      end
      OP_DIV_HOUR: begin
        if (cmd.idx[0]) begin
          hh_q <= hour_prod[HOUR_SHIFT +: HOUR_BITS];
        end else begin
          rem <= rem - ({27'd0, hh_q} * SECS_PER_HOUR);
        end
      end
      OP_DIV_MIN: begin
        if (cmd.idx[0]) begin
          mm_q <= min_prod[MIN_SHIFT +: MIN_BITS];
        end else begin
          rem <= rem - ({26'd0, mm_q} * SECS_PER_MIN);
        end
      end
      OP_YEAR: begin
        if (y_ok) begin
          yidx <= y_cand;
        end
      end
      OP_DOY: begin
        doy <= doy_full[8:0];
      end
      OP_EMIT: begin
        out_char <= ch;
        out_last <= (cmd.idx == IDX_W'(TEXT_LEN - 1));
      end
      default: begin
      end
    endcase
  end

  // date cache
  always_ff @(posedge clk) begin
    if (rst) begin
      cache_valid         <= 1'b0;
      cached_day_number   <= 16'd0;
      cached_year         <= BASE_YEAR;
      cached_month        <= 4'd1;
      cached_day_of_month <= 5'd1;
    end else begin
      unique case (cmd.op)
        OP_DOY: begin
          cached_year <= BASE_YEAR + {4'd0, yidx};
        end
        OP_MONTH: begin
          cached_month <= month_calc;
        end
        OP_DOM: begin
          cached_day_of_month <= dom_full[4:0];
          cached_day_number   <= day_q;
          cache_valid         <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* design/e2i_ctrl.sv */
module e2i_ctrl import e2i_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DIV_DAY  = 9'b000000010,
    S_DIV_HOUR = 9'b000000100,
    S_DIV_MIN  = 9'b000001000,
    S_CHECK    = 9'b000010000,
    S_YEAR     = 9'b000100000,
    S_DOY      = 9'b001000000,
    S_MONTH    = 9'b010000000,
    S_EMIT     = 9'b100000000
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] cnt;
  logic [IDX_W-1:0] cnt_next;
  logic             out_valid_next;
  logic             load;

  assign in_ready = (state == S_IDLE) && !rst;
  assign load     = (state == S_EMIT) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd.op     = OP_NONE;
    cmd.idx    = cnt;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.op     = OP_LOAD;
          cnt_next   = IDX_W'(1);
          state_next = S_DIV_DAY;
        end
      end
      S_DIV_DAY: begin
        cmd.op = OP_DIV_DAY;
        if (cnt == '0) begin
          cnt_next   = IDX_W'(1);
          state_next = S_DIV_HOUR;
        end else begin
          cnt_next = cnt - IDX_W'(1);
        end
      end
      S_DIV_HOUR: begin
        cmd.op = OP_DIV_HOUR;
        if (cnt == '0) begin
          cnt_next   = IDX_W'(1);
          state_next = S_DIV_MIN;
        end else begin
          cnt_next = cnt - IDX_W'(1);
        end
      end
      S_DIV_MIN: begin
        cmd.op = OP_DIV_MIN;
        if (cnt == '0) begin
          state_next = S_CHECK;
        end else begin
          cnt_next = cnt - IDX_W'(1);
        end
      end
      S_CHECK: begin
        if (stat.hit) begin
          cnt_next   = '0;
          state_next = S_EMIT;
        end else begin
          cnt_next   = IDX_W'(YEAR_BITS - 1);
          state_next = S_YEAR;
        end
      end
      S_YEAR: begin
        cmd.op = OP_YEAR;
        if (cnt == '0) begin
          state_next = S_DOY;
        end else begin
          cnt_next = cnt - IDX_W'(1);
        end
      end
      S_DOY: begin
        cmd.op     = OP_DOY;
        state_next = S_MONTH;
      end
      S_MONTH: begin
        if (cnt == '0) begin
          cmd.op   = OP_MONTH;
          cnt_next = 5'd1;
        end else begin
          cmd.op     = OP_DOM;
          cnt_next   = '0;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (load) begin
          cmd.op = OP_EMIT;
          if (cnt == IDX_W'(TEXT_LEN - 1)) begin
            cnt_next   = '0;
            state_next = S_IDLE;
          end else begin
            cnt_next = cnt + IDX_W'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* design/epoch_to_iso8601_text_top.sv */
// Turns a 32-bit unsigned count of seconds since 1970-01-01 00:00:00 UTC into the twenty
// ASCII characters YYYY-MM-DDThh:mm:ssZ, sent as twenty output beats with tlast on the Z.
// One timestamp is handled at a time: after a beat is taken the block splits the count
// by reciprocal multiplication (a quotient and a remainder step each for day, hour and
// minute), looks up the date cache and, only when the day differs from the cached one,
// runs an 8-step binary search for the year, then computes day of year, month and day
// of month. The twenty characters leave one per cycle from an output register while the
// output is not stalled; the next timestamp can be taken while the trailing Z still
// waits in the output register. Input is not taken while rst is high.
module epoch_to_iso8601_text_top import e2i_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // epoch_seconds[31:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // text_char[7:0]
  output logic        m_axis_tlast    // last_char
);

  cmd_t  cmd;
  stat_t stat;

  e2i_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  e2i_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (s_axis_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .out_char (m_axis_tdata),
    .out_last (m_axis_tlast)
  );

endmodule

/* design/e2i_checker.sv */
module e2i_checker import e2i_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  // one timestamp at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken twice in a row");

  // last beat is the trailing Z
  a_last_z: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == CH_Z)
    else $error("last beat is not Z");

  // only timestamp characters appear
  a_charset: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      (m_axis_tdata >= CH_ZERO && m_axis_tdata <= CH_NINE) ||
      m_axis_tdata == CH_DASH || m_axis_tdata == CH_T ||
      m_axis_tdata == CH_COLON || m_axis_tdata == CH_Z)
    else $error("unexpected output character");

  // input is never taken while output beats of the item are pending mid-text
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input ready during text output");

endmodule

bind epoch_to_iso8601_text_top e2i_checker u_e2i_checker (.*);
